// ===== src/hssc_pkg.sv =====
// Package for the hall six-step commutator core.
// Holds the transaction types, the command and register codes and the commutation tables.
// No dependencies.
package hssc_pkg;

    // Command codes carried in the func field.
    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_ALIGN  = 3'd1,
        FUNC_START  = 3'd2,
        FUNC_CANCEL = 3'd3,
        FUNC_STOP   = 3'd4
    } t_func;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_REVERSE    = 2'd0,
        REG_MIRROR     = 2'd1,
        REG_STEP_TOTAL = 2'd2,
        REG_DUTY       = 2'd3
    } t_reg_idx;

    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [5:0] DUTY_MIN   = 6'd10;
    localparam logic [5:0] DUTY_MAX   = 6'd40;
    localparam logic [5:0] DUTY_RESET = 6'd25;
    localparam logic [2:0] STEP_MAX   = 3'd6;

    // One command transaction.
    typedef struct packed {
        logic [2:0] func;
        logic [2:0] hall;
    } t_cmd_item;

    // One result transaction.
    typedef struct packed {
        logic [5:0]  gate_pattern;
        logic [5:0]  on_time;
        logic [5:0]  off_time;
        logic [2:0]  step_now;
        logic        busy_res;
        logic [2:0]  hall_now;
        logic [15:0] longest_period;
    } t_res_item;

    // Hall code to commutation step; invalid codes give step 0.
    function automatic logic [2:0] hall_to_step(input logic [2:0] hall);
        logic [2:0] s;
        unique case (hall)
            3'd1:    s = 3'd4;
            3'd2:    s = 3'd2;
            3'd3:    s = 3'd3;
            3'd4:    s = 3'd6;
            3'd5:    s = 3'd5;
            3'd6:    s = 3'd1;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // Commutation step to the hall code expected once that step is reached.
    function automatic logic [2:0] step_to_hall(input logic [2:0] step);
        logic [2:0] h;
        unique case (step)
            3'd1:    h = 3'd6;
            3'd2:    h = 3'd2;
            3'd3:    h = 3'd3;
            3'd4:    h = 3'd1;
            3'd5:    h = 3'd5;
            3'd6:    h = 3'd4;
            default: h = 3'd0;
        endcase
        return h;
    endfunction

    // Gate bits per step: low side U,V,W in bits 0-2, high side in bits 3-5.
    function automatic logic [5:0] gate_of_step(input logic [2:0] step);
        logic [5:0] g;
        unique case (step)
            3'd1:    g = 6'd34;
            3'd2:    g = 6'd33;
            3'd3:    g = 6'd17;
            3'd4:    g = 6'd20;
            3'd5:    g = 6'd12;
            3'd6:    g = 6'd10;
            default: g = 6'd0;
        endcase
        return g;
    endfunction

endpackage

// ===== src/hssc_stream_if.sv =====
// Valid/ready stream interface used for the command and result channels.
// The payload type is a parameter; the types come from hssc_pkg.
interface hssc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/hall_six_step_commutator_core.sv =====
// Top level of the hall six-step commutator: command decode, step state and result register.
// Depends on hssc_pkg and hssc_stream_if.
//
//  Channel   Direction  Payload      Handshake
//  i_cmd     in         t_cmd_item   valid/ready, taken when both high
//  o_res     out        t_res_item   valid/ready, one result per command
//  i_cfg_*   in         reg writes   write enable, no back-pressure
//
// The state is updated and each command's result registered at the accepting edge, so a
// command can be taken in every cycle. The single result register sets the rate: a new
// command is taken whenever it is empty or being emptied in the same cycle. A stalled
// result blocks further commands. Reset is synchronous and active low; it clears the
// state, the registers to their defaults and the result valid.
module hall_six_step_commutator_core #(
    parameter int unsigned PWM_PERIOD  = 50,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  hssc_pkg::t_reg_idx             i_cfg_idx,
    input  logic [hssc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hssc_stream_if.sink                    i_cmd,
    hssc_stream_if.source                  o_res
);
    import hssc_pkg::*;

    localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {COUNT_WIDTH{1'b1}};
    localparam logic [8:0] PERIOD_9 = 9'(PWM_PERIOD);

    // Configuration registers.
    logic        r_reverse;
    logic        r_mirror;
    logic [15:0] r_step_total;
    logic [5:0]  r_duty;

    // Commutation state.
    logic [2:0]             r_hall_seen, n_hall_seen;
    logic [2:0]             r_step, n_step;
    logic [2:0]             r_target, n_target;
    logic [COUNT_WIDTH-1:0] r_moved, n_moved;
    logic [COUNT_WIDTH-1:0] r_period, n_period;
    logic [COUNT_WIDTH-1:0] r_max, n_max;

    // Result register.
    logic      r_res_valid;
    t_res_item r_res;
    t_res_item n_res;

    logic           w_accept;
    logic [5:0]     w_duty_clamped;
    logic [2:0]     w_step_adv;
    logic [8:0]     w_off_9;
    logic [CMP_W-1:0] w_max_ext;
    logic [COUNT_WIDTH-1:0] w_period_inc;
    logic [COUNT_WIDTH-1:0] w_moved_inc;

    // Handshake: the result register is free or being emptied this cycle.
    assign i_cmd.ready   = !r_res_valid || o_res.ready;
    assign w_accept      = i_cmd.valid && i_cmd.ready;
    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

    // Duty writes are clamped into the legal on-time range.
    always_comb begin
        w_duty_clamped = i_cfg_data[5:0];
        if (w_duty_clamped < DUTY_MIN) begin
            w_duty_clamped = DUTY_MIN;
        end else if (w_duty_clamped > DUTY_MAX) begin
            w_duty_clamped = DUTY_MAX;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse    <= 1'b1;
            r_mirror     <= 1'b0;
            r_step_total <= '0;
            r_duty       <= DUTY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_REVERSE:    r_reverse    <= i_cfg_data[0];
                REG_MIRROR:     r_mirror     <= i_cfg_data[0];
                REG_STEP_TOTAL: r_step_total <= i_cfg_data[15:0];
                REG_DUTY:       r_duty       <= w_duty_clamped;
                default:        r_reverse    <= r_reverse;
            endcase
        end
    end

    // Saturating counter increments.
    assign w_period_inc = (r_period == COUNT_LIMIT) ? r_period : r_period + 1'b1;
    assign w_moved_inc  = (r_moved == COUNT_LIMIT) ? r_moved : r_moved + 1'b1;

    // Next step: upward when reverse equals mirror, wrapping within 1..6.
    always_comb begin
        if (r_reverse == r_mirror) begin
            w_step_adv = (r_step >= STEP_MAX) ? 3'd1 : r_step + 3'd1;
        end else begin
            w_step_adv = (r_step <= 3'd1) ? STEP_MAX : r_step - 3'd1;
        end
    end

    // Command decode and state update.
    always_comb begin
        n_hall_seen = r_hall_seen;
        n_step      = r_step;
        n_target    = r_target;
        n_moved     = r_moved;
        n_period    = r_period;
        n_max       = r_max;
        unique case (t_func'(i_cmd.payload.func))
            FUNC_TICK: begin
                n_hall_seen = i_cmd.payload.hall;
                if (r_target != 3'd0) begin
                    n_period = w_period_inc;
                    if (i_cmd.payload.hall == r_target) begin
                        n_moved = w_moved_inc;
                        if (CMP_W'(w_moved_inc) < CMP_W'(r_step_total)) begin
                            n_step   = w_step_adv;
                            n_target = step_to_hall(w_step_adv);
                        end else begin
                            n_target = 3'd0;
                        end
                        if (w_period_inc > r_max) begin
                            n_max = w_period_inc;
                        end
                        n_period = '0;
                    end
                end else begin
                    n_moved = '0;
                end
            end
            FUNC_ALIGN:  n_step = hall_to_step(r_hall_seen);
            FUNC_START:  n_target = r_hall_seen;
            FUNC_CANCEL: n_target = 3'd0;
            FUNC_STOP: begin
                n_step   = 3'd0;
                n_target = 3'd0;
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    // Result fields from the state after this command.
    assign w_off_9   = PERIOD_9 - 9'(r_duty);
    assign w_max_ext = CMP_W'(n_max);

    always_comb begin
        n_res.gate_pattern   = gate_of_step(n_step);
        n_res.on_time        = r_duty;
        n_res.off_time       = (w_off_9 > 9'd63) ? 6'd63 : w_off_9[5:0];
        n_res.step_now       = n_step;
        n_res.busy_res       = (n_target != 3'd0);
        n_res.hall_now       = n_hall_seen;
        n_res.longest_period = w_max_ext[15:0];
    end

    // State registers, updated once per accepted command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hall_seen <= '0;
            r_step      <= '0;
            r_target    <= '0;
            r_moved     <= '0;
            r_period    <= '0;
            r_max       <= '0;
        end else if (w_accept) begin
            r_hall_seen <= n_hall_seen;
            r_step      <= n_step;
            r_target    <= n_target;
            r_moved     <= n_moved;
            r_period    <= n_period;
            r_max       <= n_max;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted command.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

endmodule
